// File: hdl/mprc_pkg.sv
// Package for the match pair relation check block.
// Holds field widths, stream word widths and the result type; no dependencies.
`default_nettype none

package mprc_pkg;

  localparam int unsigned StartW  = 33;
  localparam int unsigned LengthW = 32;
  // Signed width for starts, negated starts and their differences.
  localparam int unsigned DiffW   = 36;
  localparam int unsigned SumW    = 40;

  // Input word: start_a, start_b, length_a, length_b, padded to whole bytes.
  localparam int unsigned InPackW = 2 * StartW + 2 * LengthW;
  localparam int unsigned InDataW = ((InPackW + 7) / 8) * 8;
  localparam int unsigned OutDataW = 8;

  // Bit positions of the relation flags.
  localparam int unsigned RelEven  = 0;
  localparam int unsigned RelInter = 1;
  localparam int unsigned RelCont  = 2;

  typedef struct packed {
    logic contains;
    logic evenly_overlaps;
    logic intersects;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/mprc_core.sv
// Per-word relation tracking for the match pair relation check.
// Updates anchors, flips, differences and offset sums; uses mprc_pkg.
`default_nettype none

module mprc_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [mprc_pkg::StartW-1:0]   start_a_i,
  input  wire logic [mprc_pkg::StartW-1:0]   start_b_i,
  input  wire logic [mprc_pkg::LengthW-1:0]  length_a_i,
  input  wire logic [mprc_pkg::LengthW-1:0]  length_b_i,
  input  wire logic                          last_seq_i,
  output mprc_pkg::result_t                  result_o
);

  localparam int unsigned DW = mprc_pkg::DiffW;
  localparam int unsigned SW = mprc_pkg::SumW;
  localparam int unsigned AW = mprc_pkg::StartW;
  localparam int unsigned LW = mprc_pkg::LengthW;

  logic                 run_q, run_d;
  logic [2:0]           found_q, found_d;
  logic [3:0]           flip_q, flip_d;
  logic [2:0]           alive_q, alive_d;
  logic signed [DW-1:0] ref_q [3];
  logic signed [DW-1:0] ref_d [3];
  logic signed [DW-1:0] rc_q [3];
  logic signed [DW-1:0] rc_d [3];
  logic [AW-1:0]        oref_a_q, oref_a_d, oref_b_q, oref_b_d;
  logic [SW-1:0]        sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [LW-1:0]        held_a_q, held_a_d, held_b_q, held_b_d;

  logic signed [DW-1:0] a_x, b_x, na_x, nb_x, la_x, lb_x, lenrc;
  logic signed [DW-1:0] e_s1, e_s2, e_d, i_s1, i_s2, i_d, c_d;
  logic signed [DW-1:0] l0_s1, l0_s2, l1_s1, l1_s2;
  logic signed [DW-1:0] oref_a_x, oref_b_x, off_a, off_b;
  logic                 a_nz, b_nz, a_neg, b_neg, a_seen, b_seen;
  logic [LW-1:0]        la, lb;

  // True when a later word breaks the relation anchored at slot k.
  function automatic logic breaks(input logic signed [DW-1:0] ref_v,
                                  input logic signed [DW-1:0] rc_v,
                                  input logic signed [DW-1:0] s1,
                                  input logic signed [DW-1:0] s2);
    logic signed [DW-1:0] di;
    di = s2 - s1;
    return !(s2 < 0 && rc_v == di) && (ref_v != di);
  endfunction

  always_comb begin
    a_x   = DW'(signed'(start_a_i));
    b_x   = DW'(signed'(start_b_i));
    na_x  = -a_x;
    nb_x  = -b_x;
    a_nz  = |start_a_i;
    b_nz  = |start_b_i;
    a_neg = start_a_i[AW-1];
    b_neg = start_b_i[AW-1];
    // Lengths are sampled on the first word of a pair.
    la    = run_q ? held_a_q : length_a_i;
    lb    = run_q ? held_b_q : length_b_i;
    la_x  = DW'(la);
    lb_x  = DW'(lb);
    lenrc = lb_x - la_x;
    a_seen = |oref_a_q;
    b_seen = |oref_b_q;
    oref_a_x = DW'(signed'(oref_a_q));
    oref_b_x = DW'(signed'(oref_b_q));

    e_s1 = (b_seen && a_neg) ? na_x : a_x;
    e_s2 = (b_seen && b_neg) ? nb_x : b_x;
    e_d  = e_s2 - e_s1;
    i_s1 = ((a_seen || b_seen) && a_neg) ? na_x : a_x;
    i_s2 = ((a_seen || b_seen) && b_neg) ? nb_x : b_x;
    i_d  = i_s2 - i_s1;
    c_d  = b_x - a_x;
    l0_s1 = flip_q[0] ? na_x : a_x;
    l0_s2 = flip_q[1] ? nb_x : b_x;
    l1_s1 = flip_q[2] ? na_x : a_x;
    l1_s2 = flip_q[3] ? nb_x : b_x;

    run_d   = run_q;
    found_d = found_q;
    flip_d  = flip_q;
    alive_d = alive_q;
    ref_d   = ref_q;
    rc_d    = rc_q;
    held_a_d = held_a_q;
    held_b_d = held_b_q;
    oref_a_d = oref_a_q;
    oref_b_d = oref_b_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;

    if (accept_i) begin
      run_d    = 1'b1;
      held_a_d = la;
      held_b_d = lb;

      // evenly overlaps: anchored at A's first present index
      if (!found_q[mprc_pkg::RelEven]) begin
        if (a_nz) begin
          found_d[mprc_pkg::RelEven] = 1'b1;
          if (!b_nz) begin
            alive_d[mprc_pkg::RelEven] = 1'b0;
          end else begin
            flip_d[0] = b_seen && a_neg;
            flip_d[1] = b_seen && b_neg;
            ref_d[mprc_pkg::RelEven] = e_d;
            rc_d[mprc_pkg::RelEven]  = lenrc + e_d;
            if (e_d >= la_x || -e_d >= lb_x) alive_d[mprc_pkg::RelEven] = 1'b0;
          end
        end
      end else if (a_nz) begin
        if (l0_s2 == 0) begin
          alive_d[mprc_pkg::RelEven] = 1'b0;
        end else if (breaks(ref_q[mprc_pkg::RelEven], rc_q[mprc_pkg::RelEven],
                            l0_s1, l0_s2)) begin
          alive_d[mprc_pkg::RelEven] = 1'b0;
        end
      end

      // intersects: anchored at the first index where both are present
      if (!found_q[mprc_pkg::RelInter]) begin
        if (a_nz && b_nz) begin
          found_d[mprc_pkg::RelInter] = 1'b1;
          flip_d[2] = (a_seen || b_seen) && a_neg;
          flip_d[3] = (a_seen || b_seen) && b_neg;
          ref_d[mprc_pkg::RelInter] = i_d;
          rc_d[mprc_pkg::RelInter]  = lenrc + i_d;
          if (i_d >= la_x || -i_d >= lb_x) alive_d[mprc_pkg::RelInter] = 1'b0;
        end
      end else if (a_nz && b_nz) begin
        if (breaks(ref_q[mprc_pkg::RelInter], rc_q[mprc_pkg::RelInter], l1_s1, l1_s2)) begin
          alive_d[mprc_pkg::RelInter] = 1'b0;
        end
      end

      // contains: anchored at B's first present index, no flips
      if (!found_q[mprc_pkg::RelCont]) begin
        if (b_nz) begin
          found_d[mprc_pkg::RelCont] = 1'b1;
          ref_d[mprc_pkg::RelCont] = c_d;
          rc_d[mprc_pkg::RelCont]  = lenrc + c_d;
          if (!a_nz || c_d < 0 || la_x < lb_x + c_d) alive_d[mprc_pkg::RelCont] = 1'b0;
        end
      end else if (a_nz || b_nz) begin
        if (breaks(ref_q[mprc_pkg::RelCont], rc_q[mprc_pkg::RelCont], a_x, b_x)) begin
          alive_d[mprc_pkg::RelCont] = 1'b0;
        end
      end

      // generalized offsets against each record's first present start
      off_a = a_neg ? (a_x - la_x - oref_a_x) : (a_x - oref_a_x);
      off_b = b_neg ? (b_x - lb_x - oref_b_x) : (b_x - oref_b_x);
      if (!a_seen) begin
        oref_a_d = start_a_i;
      end else if (a_nz) begin
        sum_a_d = sum_a_q + SW'(off_a);
      end
      if (!b_seen) begin
        oref_b_d = start_b_i;
      end else if (b_nz) begin
        sum_b_d = sum_b_q + SW'(off_b);
      end
    end else begin
      off_a = '0;
      off_b = '0;
    end

    result_o.intersects      = found_d[mprc_pkg::RelInter] && alive_d[mprc_pkg::RelInter];
    result_o.evenly_overlaps = found_d[mprc_pkg::RelEven] && alive_d[mprc_pkg::RelEven];
    result_o.contains        = found_d[mprc_pkg::RelCont] && alive_d[mprc_pkg::RelCont] &&
                               (sum_a_d == sum_b_d);

    // Start the next pair clean.
    if (accept_i && last_seq_i) begin
      run_d    = 1'b0;
      found_d  = '0;
      flip_d   = '0;
      alive_d  = '1;
      oref_a_d = '0;
      oref_b_d = '0;
      sum_a_d  = '0;
      sum_b_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      found_q  <= '0;
      flip_q   <= '0;
      alive_q  <= '1;
      oref_a_q <= '0;
      oref_b_q <= '0;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
    end else begin
      run_q    <= run_d;
      found_q  <= found_d;
      flip_q   <= flip_d;
      alive_q  <= alive_d;
      oref_a_q <= oref_a_d;
      oref_b_q <= oref_b_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q    <= ref_d;
    rc_q     <= rc_d;
    held_a_q <= held_a_d;
    held_b_q <= held_b_d;
  end

endmodule

`default_nettype wire

// File: hdl/match_pair_relation_check.sv
// Top level of the match pair relation check: stream ports and result buffer.
// Instantiates mprc_core; uses mprc_pkg.
`default_nettype none

// One word per sequence index enters per clock cycle while s_tready is high.
// A pair's flags are registered into the output register, which drives the
// master side, or into the skid register while an untaken result holds the
// output register. This two-entry result buffer lets input words keep flowing
// while a result waits; s_tready falls only when both entries hold results.
// No clearing pass is needed after reset.
module match_pair_relation_check (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  // start_a[32:0], start_b[65:33], length_a[97:66], length_b[129:98], zero pad
  input  wire logic [mprc_pkg::InDataW-1:0]   s_tdata,
  input  wire logic                           s_tlast,    // last_seq
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  // intersects[0], evenly_overlaps[1], contains[2], zero pad
  output      logic [mprc_pkg::OutDataW-1:0]  m_tdata
);

  localparam int unsigned AW = mprc_pkg::StartW;
  localparam int unsigned LW = mprc_pkg::LengthW;

  logic              accept;
  logic              push;
  logic              out_ready;
  mprc_pkg::result_t result;
  mprc_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign s_tready  = !skid_valid_q;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && s_tlast;
  assign out_ready = !out_valid_q || m_tready;

  mprc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .start_a_i  (s_tdata[AW-1:0]),
    .start_b_i  (s_tdata[2*AW-1:AW]),
    .length_a_i (s_tdata[2*AW+LW-1:2*AW]),
    .length_b_i (s_tdata[2*AW+2*LW-1:2*AW+LW]),
    .last_seq_i (s_tlast),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      // drain the skid entry first; no push can coincide with it
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (push) begin
      skid_q <= result;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {{(mprc_pkg::OutDataW - 3){1'b0}},
                     out_q.contains, out_q.evenly_overlaps, out_q.intersects};

endmodule

`default_nettype wire

// File: test/tb_match_pair_relation_check.sv
// Testbench for match_pair_relation_check: drives pairs of match records word by word
// and checks the relation flags against a cycle-free predictor kept in this file.
// Depends on mprc_pkg and the match_pair_relation_check top level only.
`timescale 1ns / 100ps

module tb_match_pair_relation_check;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PadW = mprc_pkg::InDataW - mprc_pkg::InPackW;
  // Bits of the strand flip register.
  localparam int unsigned FlipEvenA  = 0;
  localparam int unsigned FlipEvenB  = 1;
  localparam int unsigned FlipInterA = 2;
  localparam int unsigned FlipInterB = 3;
  localparam int unsigned RecA = 0;
  localparam int unsigned RecB = 1;

  typedef struct {
    logic signed [mprc_pkg::StartW-1:0] start_a;
    logic signed [mprc_pkg::StartW-1:0] start_b;
    logic [mprc_pkg::LengthW-1:0]       length_a;
    logic [mprc_pkg::LengthW-1:0]       length_b;
    logic                               last_seq;
  } pair_word_t;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [mprc_pkg::InDataW-1:0]  s_tdata  = '0;
  logic                          s_tlast  = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [mprc_pkg::OutDataW-1:0] m_tdata;

  match_pair_relation_check dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Relation tracker state, one pair at a time.
  bit [4:0]                   seq_cnt;
  bit [2:0]                   anchored;
  bit [3:0]                   flips;
  longint                     ref_diff [3];
  longint                     rc_diff [3];
  bit [2:0]                   alive;
  longint                     first_start [2];
  bit [mprc_pkg::SumW-1:0]    offset_sum [2];
  bit [mprc_pkg::LengthW-1:0] held_len [2];

  mprc_pkg::result_t pair_flags_q [$];
  int      err_count;
  int      words_sent;
  int      pairs_sent;
  int      hits_inter, hits_even, hits_cont;
  int      cycle_cnt;
  bit      calm;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_tracker();
    seq_cnt  = '0;
    anchored = '0;
    flips    = '0;
    alive    = '1;
    for (int k = 0; k < 3; k++) begin
      ref_diff[k] = 0;
      rc_diff[k]  = 0;
    end
    for (int k = 0; k < 2; k++) begin
      first_start[k] = 0;
      offset_sum[k]  = '0;
      held_len[k]    = '0;
    end
  endfunction

  // Compare a later index against the anchor difference of relation rel.
  function automatic void check_anchor(int unsigned rel, longint s1, longint s2, bit skip);
    longint di;
    di = s2 - s1;
    if (skip) return;
    if (s2 < 0 && rc_diff[rel] == di) return;
    if (ref_diff[rel] != di) alive[rel] = 1'b0;
  endfunction

  function automatic void add_offset(int unsigned rec, longint s, longint len);
    longint off;
    if (first_start[rec] == 0) begin
      first_start[rec] = s;
    end else if (s != 0) begin
      off = (s > 0) ? s - first_start[rec] : s - len - first_start[rec];
      offset_sum[rec] = offset_sum[rec] + off[mprc_pkg::SumW-1:0];
    end
  endfunction

  // Advance the tracker by one word; returns 1 with the flags when the pair closes.
  function automatic bit track_pair_word(input pair_word_t w,
                                         output mprc_pkg::result_t flags);
    longint a, b, la, lb, s1, s2, d;
    bit     a_seen, b_seen;
    a = longint'(w.start_a);
    b = longint'(w.start_b);
    if (seq_cnt == 0) begin
      held_len[RecA] = w.length_a;
      held_len[RecB] = w.length_b;
    end
    la = held_len[RecA];
    lb = held_len[RecB];
    a_seen = first_start[RecA] != 0;
    b_seen = first_start[RecB] != 0;

    // Evenly overlaps: anchored at the first index where A is present.
    if (!anchored[mprc_pkg::RelEven]) begin
      if (a != 0) begin
        anchored[mprc_pkg::RelEven] = 1'b1;
        if (b == 0) begin
          alive[mprc_pkg::RelEven] = 1'b0;
        end else begin
          s1 = a;
          s2 = b;
          if (b_seen) begin
            if (a < 0) begin
              flips[FlipEvenA] = 1'b1;
              s1 = -a;
            end
            if (b < 0) begin
              flips[FlipEvenB] = 1'b1;
              s2 = -b;
            end
          end
          d = s2 - s1;
          ref_diff[mprc_pkg::RelEven] = d;
          rc_diff[mprc_pkg::RelEven]  = lb - la + d;
          if (d >= la || -d >= lb) alive[mprc_pkg::RelEven] = 1'b0;
        end
      end
    end else begin
      s1 = flips[FlipEvenA] ? -a : a;
      s2 = flips[FlipEvenB] ? -b : b;
      if (s1 != 0 && s2 == 0) alive[mprc_pkg::RelEven] = 1'b0;
      else check_anchor(mprc_pkg::RelEven, s1, s2, s1 == 0);
    end

    // Intersects: anchored at the first index where both are present.
    if (!anchored[mprc_pkg::RelInter]) begin
      if (a != 0 && b != 0) begin
        anchored[mprc_pkg::RelInter] = 1'b1;
        s1 = a;
        s2 = b;
        if (a_seen || b_seen) begin
          if (a < 0) begin
            flips[FlipInterA] = 1'b1;
            s1 = -a;
          end
          if (b < 0) begin
            flips[FlipInterB] = 1'b1;
            s2 = -b;
          end
        end
        d = s2 - s1;
        ref_diff[mprc_pkg::RelInter] = d;
        rc_diff[mprc_pkg::RelInter]  = lb - la + d;
        if (d >= la || -d >= lb) alive[mprc_pkg::RelInter] = 1'b0;
      end
    end else begin
      s1 = flips[FlipInterA] ? -a : a;
      s2 = flips[FlipInterB] ? -b : b;
      check_anchor(mprc_pkg::RelInter, s1, s2, s1 == 0 || s2 == 0);
    end

    // Contains: anchored at the first index where B is present, strands as given.
    if (!anchored[mprc_pkg::RelCont]) begin
      if (b != 0) begin
        anchored[mprc_pkg::RelCont] = 1'b1;
        d = b - a;
        ref_diff[mprc_pkg::RelCont] = d;
        rc_diff[mprc_pkg::RelCont]  = lb - la + d;
        if (a == 0 || d < 0 || la < lb + d) alive[mprc_pkg::RelCont] = 1'b0;
      end
    end else begin
      check_anchor(mprc_pkg::RelCont, a, b, a == 0 && b == 0);
    end

    add_offset(RecA, a, la);
    add_offset(RecB, b, lb);
    if (seq_cnt < 16) seq_cnt++;

    flags = '0;
    if (!w.last_seq) return 1'b0;
    flags.intersects      = anchored[mprc_pkg::RelInter] && alive[mprc_pkg::RelInter];
    flags.evenly_overlaps = anchored[mprc_pkg::RelEven] && alive[mprc_pkg::RelEven];
    flags.contains        = anchored[mprc_pkg::RelCont] && alive[mprc_pkg::RelCont] &&
                            offset_sum[RecA] == offset_sum[RecB];
    clear_tracker();
    return 1'b1;
  endfunction

  // Present one word, hold it until taken, then log the flags it closes.
  task automatic send_word(input pair_word_t w);
    mprc_pkg::result_t flags;
    if (!calm && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PadW{1'b0}}, w.length_b, w.length_a, w.start_b, w.start_a};
    s_tlast  <= w.last_seq;
    do @(posedge clk_i); while (!s_tready);
    words_sent++;
    if (track_pair_word(w, flags)) begin
      pair_flags_q = {pair_flags_q, flags};
      pairs_sent++;
      hits_inter += flags.intersects;
      hits_even  += flags.evenly_overlaps;
      hits_cont  += flags.contains;
    end
  endtask

  task automatic send_fields(input longint a, input longint b, input longint la,
                             input longint lb, input bit last);
    pair_word_t w;
    w.start_a  = a[mprc_pkg::StartW-1:0];
    w.start_b  = b[mprc_pkg::StartW-1:0];
    w.length_a = la[mprc_pkg::LengthW-1:0];
    w.length_b = lb[mprc_pkg::LengthW-1:0];
    w.last_seq = last;
    send_word(w);
  endtask

  function automatic longint pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 4000);
    if (r < 85) return longint'($urandom);
    if (r < 92) return 0;
    return longint'($urandom_range(32'hFFFF_F000, 32'hFFFF_FFFF));
  endfunction

  // One pair built around a shared displacement so that relations can hold.
  task automatic send_shaped_pair();
    longint la, lb, d, p, a, b;
    int     n, r;
    la = pick_length();
    lb = pick_length();
    case ($urandom_range(3))
      0: d = (la >= lb) ? longint'($urandom_range(32'(la - lb))) : 0;
      1: d = longint'($urandom_range(8000)) - 4000;
      2: d = longint'($urandom_range(2000000)) - 1000000;
      default: d = 0;
    endcase
    n = ($urandom_range(99) < 3) ? $urandom_range(17, 40) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) p = longint'($urandom_range(32'hF000_0000, 32'hFFFF_FFFF));
      else p = longint'($urandom_range(1, 1 << 24)) + 5000000;
      if ($urandom_range(3) == 0) begin
        a = -p;
        b = $urandom_range(1) ? -p + (lb - la + d) : -(p + d);
      end else begin
        a = p;
        b = p + d;
      end
      if ($urandom_range(9) == 0) b = b + longint'($urandom_range(6)) - 3;
      r = $urandom_range(99);
      if (r >= 70 && r < 80) b = 0;
      else if (r >= 80 && r < 90) a = 0;
      else if (r >= 90) begin
        a = 0;
        b = 0;
      end
      send_fields(a, b, i == 0 ? la : longint'($urandom),
                  i == 0 ? lb : longint'($urandom), i == n - 1);
    end
  endtask

  task automatic send_noise_pair();
    longint a, b;
    int     n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      a = {$urandom_range(1), $urandom};
      b = {$urandom_range(1), $urandom};
      if ($urandom_range(4) == 0) a = 0;
      if ($urandom_range(4) == 0) b = 0;
      send_fields(a, b, longint'($urandom), longint'($urandom), i == n - 1);
    end
  endtask

  task automatic test_field_extremes();
    send_fields(64'sd4294967295, -64'sd4294967295, 32'hFFFF_FFFF, 0, 1'b1);
    send_fields(-64'sd4294967296, -64'sd4294967296, 0, 0, 1'b1);
    send_fields(-64'sd4294967295, 64'sd4294967295, 0, 32'hFFFF_FFFF, 1'b1);
    send_fields(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_fields(64'sd4294967295, 64'sd4294967290, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_fields(-64'sd4294967295, -64'sd4294967290, 5, 5, 1'b1);
  endtask

  task automatic test_missing_anchor();
    // A never present, B never present, never both present.
    send_fields(0, 5, 10, 10, 1'b0);
    send_fields(0, 9, 10, 10, 1'b1);
    send_fields(5, 0, 10, 10, 1'b0);
    send_fields(7, 0, 10, 10, 1'b1);
    send_fields(5, 0, 10, 10, 1'b0);
    send_fields(0, 7, 10, 10, 1'b0);
    send_fields(0, 0, 10, 10, 1'b1);
  endtask

  task automatic test_relations();
    // B inside A, forward strand.
    send_fields(1000, 1010, 100, 10, 1'b0);
    send_fields(2000, 2010, 100, 10, 1'b1);
    // B inside A, second index reverse through the complement difference.
    send_fields(1000, 1010, 100, 10, 1'b0);
    send_fields(-3000, -3080, 100, 10, 1'b1);
    // Negative difference against a huge length: must compare signed.
    send_fields(1000, 10, 5, 32'hFFFF_FFFF, 1'b0);
    send_fields(2000, 1010, 5, 32'hFFFF_FFFF, 1'b1);
    // B seen first, then both reverse: strand flips on the even anchor.
    send_fields(0, 400, 50, 50, 1'b0);
    send_fields(-1000, -1010, 50, 50, 1'b0);
    send_fields(-2000, -2010, 50, 50, 1'b1);
  endtask

  // Long pair with large offsets so the offset sums wrap past 2^40.
  task automatic test_long_pair();
    longint p;
    for (int i = 0; i < 300; i++) begin
      p = (i == 0) ? 1 : longint'($urandom_range(32'hFFFF_0000, 32'hFFFF_FFF0));
      send_fields(p, p, 1000, 10, i == 299);
    end
  endtask

  task automatic test_random_pairs(input int target);
    int base;
    base = words_sent;
    while (words_sent - base < target) begin
      if ($urandom_range(9) == 0) send_noise_pair();
      else send_shaped_pair();
    end
  endtask

  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    mprc_pkg::result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pair_flags_q.size() == 0) begin
        $error("result word with no pair pending: %b", m_tdata[2:0]);
        err_count++;
      end else begin
        want = pair_flags_q.pop_front();
        if (m_tdata[0] !== want.intersects) begin
          $error("intersects: expected %0d, got %0d", want.intersects, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[1] !== want.evenly_overlaps) begin
          $error("evenly_overlaps: expected %0d, got %0d", want.evenly_overlaps, m_tdata[1]);
          err_count++;
        end
        if (m_tdata[2] !== want.contains) begin
          $error("contains: expected %0d, got %0d", want.contains, m_tdata[2]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pair_flags_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clear_tracker();
    calm = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_missing_anchor();
    test_relations();
    calm = 1'b1;
    test_random_pairs(300);
    calm = 1'b0;
    test_long_pair();
    test_random_pairs(1300);

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (pair_flags_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d words in %0d pairs, incl. a 300-word pair wrapping the offset sums.",
             words_sent, pairs_sent);
    $display("Flags seen high: intersects %0d, evenly_overlaps %0d, contains %0d.",
             hits_inter, hits_even, hits_cont);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
